/* sv/plc_pkg.sv */
// plc_pkg: shared constants, types, coefficient tables and fixed-point helpers
// for the planckian locus chromaticity unit; depends on nothing
package plc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = FRAC_BITS + 1;
    localparam int T_W       = 15;
    localparam int CFG_W     = 13;
    localparam int COL_W     = 12;
    localparam int ROW_W     = 13;

    localparam logic [T_W-1:0] T_MIN = 15'd1500;
    localparam logic [T_W-1:0] T_MAX = 15'd25000;
    localparam logic [T_W-1:0] T_SPLIT_LOW  = 15'd2222;
    localparam logic [T_W-1:0] T_SPLIT_HIGH = 15'd4000;

    localparam logic [CFG_W-1:0] CANVAS_MIN   = 13'd2;
    localparam logic [CFG_W-1:0] CANVAS_MAX   = 13'd4096;
    localparam logic [CFG_W-1:0] CANVAS_RESET = 13'd512;

    localparam logic [0:0] REG_CANVAS_COLS = 1'b0;
    localparam logic [0:0] REG_CANVAS_ROWS = 1'b1;

    localparam logic [1:0] SEG_LOW  = 2'd0;
    localparam logic [1:0] SEG_MID  = 2'd1;
    localparam logic [1:0] SEG_HIGH = 2'd2;

    // 1000 * 2^30 / T, restoring division, DIV_STEPS quotient bits per stage
    localparam int DIV_BITS   = 32;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;
    localparam longint NUM_BASE = 64'sd1000 * 64'sd1073741824;
    localparam logic [T_W-1:0] DIV_REM_INIT = T_W'(NUM_BASE >>> DIV_BITS);

    typedef logic signed [33:0] coef_t;
    typedef logic signed [31:0] data_t;
    typedef logic signed [34:0] prod_t;
    typedef logic signed [35:0] acc_t;

    typedef struct packed {
        coef_t cub;
        coef_t sq;
        coef_t lin;
        coef_t con;
    } coef_set_t;

    typedef struct packed {
        logic [1:0] seg;
        data_t      x;
    } side_t;

    localparam longint QONE  = 64'sd1073741824;
    localparam longint QHALF = 64'sd500000000;
    localparam longint QDEN  = 64'sd1000000000;

    localparam coef_t XL_CUB = coef_t'(-((64'sd266123900 * QONE + QHALF) / QDEN));
    localparam coef_t XL_SQ  = coef_t'(-((64'sd234358900 * QONE + QHALF) / QDEN));
    localparam coef_t XL_LIN = coef_t'((64'sd877695600 * QONE + QHALF) / QDEN);
    localparam coef_t XL_CON = coef_t'((64'sd179910000 * QONE + QHALF) / QDEN);

    localparam coef_t XH_CUB = coef_t'(-((64'sd3025846900 * QONE + QHALF) / QDEN));
    localparam coef_t XH_SQ  = coef_t'((64'sd2107037900 * QONE + QHALF) / QDEN);
    localparam coef_t XH_LIN = coef_t'((64'sd222634700 * QONE + QHALF) / QDEN);
    localparam coef_t XH_CON = coef_t'((64'sd240390000 * QONE + QHALF) / QDEN);

    localparam coef_t Y1_CUB = coef_t'(-((64'sd1106381400 * QONE + QHALF) / QDEN));
    localparam coef_t Y1_SQ  = coef_t'(-((64'sd1348110200 * QONE + QHALF) / QDEN));
    localparam coef_t Y1_LIN = coef_t'((64'sd2185558320 * QONE + QHALF) / QDEN);
    localparam coef_t Y1_CON = coef_t'(-((64'sd202196830 * QONE + QHALF) / QDEN));

    localparam coef_t Y2_CUB = coef_t'(-((64'sd954947600 * QONE + QHALF) / QDEN));
    localparam coef_t Y2_SQ  = coef_t'(-((64'sd1374185930 * QONE + QHALF) / QDEN));
    localparam coef_t Y2_LIN = coef_t'((64'sd2091370150 * QONE + QHALF) / QDEN);
    localparam coef_t Y2_CON = coef_t'(-((64'sd167488670 * QONE + QHALF) / QDEN));

    localparam coef_t Y3_CUB = coef_t'((64'sd3081758000 * QONE + QHALF) / QDEN);
    localparam coef_t Y3_SQ  = coef_t'(-((64'sd5873386700 * QONE + QHALF) / QDEN));
    localparam coef_t Y3_LIN = coef_t'((64'sd3751129970 * QONE + QHALF) / QDEN);
    localparam coef_t Y3_CON = coef_t'(-((64'sd370014830 * QONE + QHALF) / QDEN));

    localparam coef_set_t XLOW  = '{cub: XL_CUB, sq: XL_SQ, lin: XL_LIN, con: XL_CON};
    localparam coef_set_t XHIGH = '{cub: XH_CUB, sq: XH_SQ, lin: XH_LIN, con: XH_CON};
    localparam coef_set_t YSEG1 = '{cub: Y1_CUB, sq: Y1_SQ, lin: Y1_LIN, con: Y1_CON};
    localparam coef_set_t YSEG2 = '{cub: Y2_CUB, sq: Y2_SQ, lin: Y2_LIN, con: Y2_CON};
    localparam coef_set_t YSEG3 = '{cub: Y3_CUB, sq: Y3_SQ, lin: Y3_LIN, con: Y3_CON};

    // q30 product, magnitude rounded half away from zero, sign restored
    function automatic prod_t qmul(input coef_t a, input data_t b);
        logic        neg;
        logic [32:0] ma;
        logic [30:0] mb;
        logic [63:0] p;
        logic [64:0] r;
        neg = a[33] ^ b[31];
        ma  = a[33] ? 33'(-a) : 33'(a);
        mb  = b[31] ? 31'(-b) : 31'(b);
        p   = {31'b0, ma} * {33'b0, mb};
        r   = {1'b0, p} + 65'd536870912;
        qmul = neg ? -prod_t'(r[64:30]) : prod_t'(r[64:30]);
    endfunction

    // q30 to output format, negative to zero, round half up, saturate at one
    function automatic logic [OUT_W-1:0] to_out(input acc_t v);
        logic [36:0] s;
        logic [36:0] r;
        s = {1'b0, v} + (37'd1 << (29 - FRAC_BITS));
        r = s >> (30 - FRAC_BITS);
        if (v[35])
            to_out = '0;
        else if (r > (37'd1 << FRAC_BITS))
            to_out = OUT_W'(1 << FRAC_BITS);
        else
            to_out = r[OUT_W-1:0];
    endfunction

endpackage

/* sv/plc_divider.sv */
// plc_divider: pipelined restoring divider forming u = round(1000 * 2^30 / T)
// depends on plc_pkg
module plc_divider
    import plc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [T_W-1:0] in_t,
    input  logic [1:0]     in_seg,
    output logic           out_valid,
    output data_t          out_u,
    output logic [1:0]     out_seg
);

    logic             valid_reg [DIV_STAGES];
    logic [T_W-1:0]   rem_reg   [DIV_STAGES];
    logic [31:0]      work_reg  [DIV_STAGES];
    logic [T_W-1:0]   t_reg     [DIV_STAGES];
    logic [1:0]       seg_reg   [DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_stage
            logic           src_valid;
            logic [T_W-1:0] src_rem;
            logic [31:0]    src_work;
            logic [T_W-1:0] src_t;
            logic [1:0]     src_seg;
            logic [T_W-1:0] rem_next;
            logic [31:0]    work_next;

            if (g == 0)
            begin : g_first
                // low numerator bits are t/2, the rounding term
                assign src_valid = in_valid;
                assign src_rem   = DIV_REM_INIT;
                assign src_work  = {18'b0, in_t[T_W-1:1]};
                assign src_t     = in_t;
                assign src_seg   = in_seg;
            end
            else
            begin : g_rest
                assign src_valid = valid_reg[g-1];
                assign src_rem   = rem_reg[g-1];
                assign src_work  = work_reg[g-1];
                assign src_t     = t_reg[g-1];
                assign src_seg   = seg_reg[g-1];
            end

            always_comb
            begin : p_steps
                logic [T_W:0] trial;
                logic [T_W-1:0] r;
                logic [31:0] w;
                r = src_rem;
                w = src_work;
                for (int k = 0; k < DIV_STEPS; k++)
                begin
                    trial = {r, w[31]};
                    if (trial >= {1'b0, src_t})
                    begin
                        r = T_W'(trial - {1'b0, src_t});
                        w = {w[30:0], 1'b1};
                    end
                    else
                    begin
                        r = trial[T_W-1:0];
                        w = {w[30:0], 1'b0};
                    end
                end
                rem_next  = r;
                work_next = w;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[g] <= 1'b0;
                else
                    valid_reg[g] <= src_valid;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g]  <= rem_next;
                work_reg[g] <= work_next;
                t_reg[g]    <= src_t;
                seg_reg[g]  <= src_seg;
            end
        end
    endgenerate

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_u     = data_t'({1'b0, work_reg[DIV_STAGES-1][30:0]});
    assign out_seg   = seg_reg[DIV_STAGES-1];

endmodule

/* sv/plc_cubic.sv */
// plc_cubic: four-stage q30 cubic c3*v^3 + c2*v^2 + c1*v + c0
// depends on plc_pkg
module plc_cubic
    import plc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  data_t     in_v,
    input  coef_set_t in_coef,
    input  side_t     in_side,
    output logic      out_valid,
    output acc_t      out_sum,
    output side_t     out_side
);

    logic [3:0] valid_reg;

    data_t     s1_v_reg, s1_v2_reg;
    prod_t     s1_p1_reg;
    coef_set_t s1_coef_reg;
    side_t     s1_side_reg;

    data_t     s2_v3_reg;
    prod_t     s2_p1_reg, s2_p2_reg;
    coef_t     s2_cub_reg, s2_con_reg;
    side_t     s2_side_reg;

    prod_t     s3_p1_reg, s3_p2_reg, s3_p3_reg;
    coef_t     s3_con_reg;
    side_t     s3_side_reg;

    acc_t      s4_sum_reg;
    side_t     s4_side_reg;

    prod_t v2_next, p1_next, v3_next, p2_next, p3_next;
    acc_t  sum_next;

    assign v2_next  = qmul(coef_t'(in_v), in_v);
    assign p1_next  = qmul(in_coef.lin, in_v);
    assign v3_next  = qmul(coef_t'(s1_v2_reg), s1_v_reg);
    assign p2_next  = qmul(s1_coef_reg.sq, s1_v2_reg);
    assign p3_next  = qmul(s2_cub_reg, s2_v3_reg);
    assign sum_next = acc_t'(s3_p3_reg) + acc_t'(s3_p2_reg) + acc_t'(s3_p1_reg)
                    + acc_t'(s3_con_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        s1_v_reg    <= in_v;
        s1_v2_reg   <= data_t'(v2_next);
        s1_p1_reg   <= p1_next;
        s1_coef_reg <= in_coef;
        s1_side_reg <= in_side;

        s2_v3_reg   <= data_t'(v3_next);
        s2_p1_reg   <= s1_p1_reg;
        s2_p2_reg   <= p2_next;
        s2_cub_reg  <= s1_coef_reg.cub;
        s2_con_reg  <= s1_coef_reg.con;
        s2_side_reg <= s1_side_reg;

        s3_p1_reg   <= s2_p1_reg;
        s3_p2_reg   <= s2_p2_reg;
        s3_p3_reg   <= p3_next;
        s3_con_reg  <= s2_con_reg;
        s3_side_reg <= s2_side_reg;

        s4_sum_reg  <= sum_next;
        s4_side_reg <= s3_side_reg;
    end

    assign out_valid = valid_reg[3];
    assign out_sum   = s4_sum_reg;
    assign out_side  = s4_side_reg;

endmodule

/* sv/plc_output.sv */
// plc_output: output formatting and canvas mapping, three stages
// depends on plc_pkg
module plc_output
    import plc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  acc_t             in_x,
    input  acc_t             in_y,
    input  logic [COL_W-1:0] cols_m1,
    input  logic [ROW_W-1:0] rows,
    output logic             out_valid,
    output logic [OUT_W-1:0] chroma_x,
    output logic [OUT_W-1:0] chroma_y,
    output logic [COL_W-1:0] pixel_col,
    output logic [ROW_W-1:0] pixel_row
);

    localparam int PROD_W = OUT_W + COL_W;

    logic [2:0] valid_reg;

    logic [OUT_W-1:0]  o1_cx_reg, o1_cy_reg;
    logic [COL_W-1:0]  o1_cm1_reg;
    logic [ROW_W-1:0]  o1_rows_reg;

    logic [OUT_W-1:0]  o2_cx_reg, o2_cy_reg;
    logic [PROD_W-1:0] o2_pcol_reg, o2_prow_reg;
    logic [ROW_W-1:0]  o2_rows_reg;

    logic [OUT_W-1:0]  o3_cx_reg, o3_cy_reg;
    logic [COL_W-1:0]  o3_col_reg;
    logic [ROW_W-1:0]  o3_row_reg;

    logic [COL_W-1:0]  rm1_next;
    logic [PROD_W:0]   up_sum_next;
    logic [ROW_W-1:0]  up_next;

    assign rm1_next    = COL_W'(o1_rows_reg - 13'd1);
    // row counts from the top: rows minus y scaled, rounded up
    assign up_sum_next = {1'b0, o2_prow_reg} + ((PROD_W+1)'(1) << FRAC_BITS)
                       - (PROD_W+1)'(1);
    assign up_next     = ROW_W'(up_sum_next >> FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        o1_cx_reg   <= to_out(in_x);
        o1_cy_reg   <= to_out(in_y);
        o1_cm1_reg  <= cols_m1;
        o1_rows_reg <= rows;

        o2_cx_reg   <= o1_cx_reg;
        o2_cy_reg   <= o1_cy_reg;
        o2_pcol_reg <= {{COL_W{1'b0}}, o1_cx_reg} * {{OUT_W{1'b0}}, o1_cm1_reg};
        o2_prow_reg <= {{COL_W{1'b0}}, o1_cy_reg} * {{OUT_W{1'b0}}, rm1_next};
        o2_rows_reg <= o1_rows_reg;

        o3_cx_reg   <= o2_cx_reg;
        o3_cy_reg   <= o2_cy_reg;
        o3_col_reg  <= COL_W'(o2_pcol_reg >> FRAC_BITS);
        o3_row_reg  <= o2_rows_reg - up_next;
    end

    assign out_valid = valid_reg[2];
    assign chroma_x  = o3_cx_reg;
    assign chroma_y  = o3_cy_reg;
    assign pixel_col = o3_col_reg;
    assign pixel_row = o3_row_reg;

endmodule

/* sv/planckian_locus_chromaticity_unit.sv */
// planckian locus chromaticity unit: temperature in, cie 1931 x/y and canvas pixel out
// pipeline from start to done: 1 input, 8 divider, 4 + 4 cubic, 3 output stages
// throughput one transaction per cycle; busy stays low, done pulses for one cycle
// reset clears the valid pipeline and sets both canvas registers to 512
// depends on plc_pkg, plc_divider, plc_cubic, plc_output
module planckian_locus_chromaticity_unit
    import plc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [T_W-1:0]   temperature_k,
    output logic             done,
    output logic [OUT_W-1:0] chroma_x,
    output logic [OUT_W-1:0] chroma_y,
    output logic [COL_W-1:0] pixel_col,
    output logic [ROW_W-1:0] pixel_row,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] cols_reg, rows_reg;
    logic [CFG_W-1:0] cols_clamp, rows_clamp;

    logic           in_valid_reg;
    logic [T_W-1:0] in_t_reg;
    logic [1:0]     in_seg_reg;
    logic [T_W-1:0] t_next;
    logic [1:0]     seg_next;

    logic       div_valid;
    data_t      div_u;
    logic [1:0] div_seg;

    coef_set_t  xcoef, ycoef;
    side_t      xside, xside_out, yside_out;
    logic       x_valid, y_valid;
    acc_t       x_sum, y_sum;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CANVAS_RESET;
            rows_reg <= CANVAS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CANVAS_COLS: cols_reg <= cfg_data;
                REG_CANVAS_ROWS: rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cols_clamp = cols_reg;
        if (cols_reg < CANVAS_MIN)
            cols_clamp = CANVAS_MIN;
        else if (cols_reg > CANVAS_MAX)
            cols_clamp = CANVAS_MAX;
        rows_clamp = rows_reg;
        if (rows_reg < CANVAS_MIN)
            rows_clamp = CANVAS_MIN;
        else if (rows_reg > CANVAS_MAX)
            rows_clamp = CANVAS_MAX;
    end

    always_comb
    begin
        t_next = temperature_k;
        if (temperature_k < T_MIN)
            t_next = T_MIN;
        else if (temperature_k > T_MAX)
            t_next = T_MAX;
        if (t_next <= T_SPLIT_LOW)
            seg_next = SEG_LOW;
        else if (t_next <= T_SPLIT_HIGH)
            seg_next = SEG_MID;
        else
            seg_next = SEG_HIGH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_t_reg   <= t_next;
        in_seg_reg <= seg_next;
    end

    plc_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_t      (in_t_reg),
        .in_seg    (in_seg_reg),
        .out_valid (div_valid),
        .out_u     (div_u),
        .out_seg   (div_seg)
    );

    assign xcoef = (div_seg == SEG_HIGH) ? XHIGH : XLOW;
    assign xside = '{seg: div_seg, x: '0};

    plc_cubic u_cubic_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_v      (div_u),
        .in_coef   (xcoef),
        .in_side   (xside),
        .out_valid (x_valid),
        .out_sum   (x_sum),
        .out_side  (xside_out)
    );

    always_comb
    begin
        case (xside_out.seg)
            SEG_LOW:  ycoef = YSEG1;
            SEG_MID:  ycoef = YSEG2;
            default:  ycoef = YSEG3;
        endcase
    end

    plc_cubic u_cubic_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x_valid),
        .in_v      (data_t'(x_sum)),
        .in_coef   (ycoef),
        .in_side   ('{seg: xside_out.seg, x: data_t'(x_sum)}),
        .out_valid (y_valid),
        .out_sum   (y_sum),
        .out_side  (yside_out)
    );

    plc_output u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (y_valid),
        .in_x      (acc_t'(yside_out.x)),
        .in_y      (y_sum),
        .cols_m1   (COL_W'(cols_clamp - 13'd1)),
        .rows      (rows_clamp),
        .out_valid (done),
        .chroma_x  (chroma_x),
        .chroma_y  (chroma_y),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row)
    );

endmodule

/* bench/tb_planckian_locus_chromaticity_unit.sv */
// testbench for planckian_locus_chromaticity_unit: directed table plus random temperatures,
// each checked against a fixed-point locus predictor; depends on plc_pkg and the unit rtl
`timescale 1ns / 100ps

module tb_planckian_locus_chromaticity_unit;
    import plc_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [T_W-1:0]   temperature_k;
    logic             done;
    logic [OUT_W-1:0] chroma_x;
    logic [OUT_W-1:0] chroma_y;
    logic [COL_W-1:0] pixel_col;
    logic [ROW_W-1:0] pixel_row;
    logic             cfg_we;
    logic [0:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    typedef struct {
        logic [OUT_W-1:0] cx;
        logic [OUT_W-1:0] cy;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } locus_point_t;

    typedef struct {
        logic [T_W-1:0] temp;
        bit             typed;
        locus_point_t   pt;
    } stim_row_t;

    locus_point_t pending_points[$];
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    int mismatch_count;

    planckian_locus_chromaticity_unit dut (.*);

    always #5 clk = ~clk;

    function automatic longint q30_scale(input longint micro);
        longint m;
        m = micro < 0 ? -micro : micro;
        m = (m * 64'sd1073741824 + 64'sd500000000) / 64'sd1000000000;
        return micro < 0 ? -m : m;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        bit neg;
        longint unsigned ma, mb, r;
        neg = (a < 0) != (b < 0);
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        r = (ma * mb + (64'd1 << 29)) >> 30;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint eval_cubic(input longint c3, c2, c1, c0, v);
        longint v2, v3;
        v2 = q30_mul(v, v);
        v3 = q30_mul(v2, v);
        return q30_mul(q30_scale(c3), v3) + q30_mul(q30_scale(c2), v2)
            + q30_mul(q30_scale(c1), v) + q30_scale(c0);
    endfunction

    function automatic logic [OUT_W-1:0] q30_to_fixed(input longint v);
        longint r;
        if (v < 0)
            return '0;
        r = (v + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        return r > (64'sd1 << FRAC_BITS) ? OUT_W'(1 << FRAC_BITS) : OUT_W'(r);
    endfunction

    function automatic longint canvas_size(input logic [CFG_W-1:0] v);
        if (v < CANVAS_MIN)
            return CANVAS_MIN;
        if (v > CANVAS_MAX)
            return CANVAS_MAX;
        return v;
    endfunction

    function automatic locus_point_t predict_locus(input logic [T_W-1:0] temp_in);
        longint t, u, x, y, cols, rows, up;
        locus_point_t p;
        t = temp_in;
        if (t < T_MIN)
            t = T_MIN;
        if (t > T_MAX)
            t = T_MAX;
        u = (64'sd1000 * 64'sd1073741824 + t / 2) / t;
        if (t <= T_SPLIT_HIGH)
            x = eval_cubic(-64'sd266123900, -64'sd234358900, 64'sd877695600,
                           64'sd179910000, u);
        else
            x = eval_cubic(-64'sd3025846900, 64'sd2107037900, 64'sd222634700,
                           64'sd240390000, u);
        if (t <= T_SPLIT_LOW)
            y = eval_cubic(-64'sd1106381400, -64'sd1348110200, 64'sd2185558320,
                           -64'sd202196830, x);
        else if (t <= T_SPLIT_HIGH)
            y = eval_cubic(-64'sd954947600, -64'sd1374185930, 64'sd2091370150,
                           -64'sd167488670, x);
        else
            y = eval_cubic(64'sd3081758000, -64'sd5873386700, 64'sd3751129970,
                           -64'sd370014830, x);
        p.cx = q30_to_fixed(x);
        p.cy = q30_to_fixed(y);
        cols = canvas_size(cols_reg);
        rows = canvas_size(rows_reg);
        p.col = COL_W'((longint'(p.cx) * (cols - 1)) >>> FRAC_BITS);
        up = (longint'(p.cy) * (rows - 1) + (64'sd1 << FRAC_BITS) - 1) >>> FRAC_BITS;
        p.row = ROW_W'(rows - up);
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // results are taken at the edge ending the done cycle
    always @(posedge clk)
    begin
        locus_point_t want;
        if (rst_n && done)
        begin
            if (pending_points.size() == 0)
                report_mismatch("unexpected transaction", 0, 0);
            else
            begin
                want = pending_points.pop_front();
                if (chroma_x !== want.cx)
                    report_mismatch("chroma_x", chroma_x, want.cx);
                if (chroma_y !== want.cy)
                    report_mismatch("chroma_y", chroma_y, want.cy);
                if (pixel_col !== want.col)
                    report_mismatch("pixel_col", pixel_col, want.col);
                if (pixel_row !== want.row)
                    report_mismatch("pixel_row", pixel_row, want.row);
            end
        end
    end

    // after each write the task idles with the enable low, so each call makes one update
    task automatic write_canvas(input logic [0:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_CANVAS_COLS)
            cols_reg = value;
        else
            rows_reg = value;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // one transaction; start stays high across back-to-back items
    task automatic send_temp(input logic [T_W-1:0] temp, input bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 8) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            temperature_k <= T_W'($urandom);
            repeat (gap)
                @(posedge clk);
        end
        start <= 1'b1;
        temperature_k <= temp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_points.push_back(predict_locus(temp));
    endtask

    function automatic logic [T_W-1:0] random_temp();
        case ($urandom_range(0, 9))
            0: return T_W'($urandom);
            1: return T_W'($urandom_range(2212, 2232));
            2: return T_W'($urandom_range(3990, 4010));
            3: return T_W'($urandom_range(1490, 1510));
            4: return T_W'($urandom_range(24990, 25010));
            default: return T_W'($urandom_range(1500, 25000));
        endcase
    endfunction

    stim_row_t directed_rows[] = '{
        '{15'd0, 1'b0, '{0, 0, 0, 0}},
        '{15'd1499, 1'b0, '{0, 0, 0, 0}},
        '{15'd1500, 1'b0, '{0, 0, 0, 0}},
        '{15'd2221, 1'b0, '{0, 0, 0, 0}},
        '{15'd2222, 1'b0, '{0, 0, 0, 0}},
        '{15'd2223, 1'b0, '{0, 0, 0, 0}},
        '{15'd3999, 1'b0, '{0, 0, 0, 0}},
        '{15'd4000, 1'b0, '{0, 0, 0, 0}},
        '{15'd4001, 1'b0, '{0, 0, 0, 0}},
        '{15'd6500, 1'b0, '{0, 0, 0, 0}},
        '{15'd25000, 1'b0, '{0, 0, 0, 0}},
        '{15'd25001, 1'b0, '{0, 0, 0, 0}},
        '{15'h7fff, 1'b0, '{0, 0, 0, 0}},
        '{15'h5555, 1'b0, '{0, 0, 0, 0}},
        '{15'h2aaa, 1'b0, '{0, 0, 0, 0}}
    };

    initial
    begin
        int n;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        temperature_k = '0;
        cfg_we = 1'b0;
        cfg_index = REG_CANVAS_COLS;
        cfg_data = '0;
        cols_reg = CANVAS_RESET;
        rows_reg = CANVAS_RESET;
        mismatch_count = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_temp(directed_rows[i].temp, 1'b0);
        start <= 1'b0;
        drain_results();

        // canvas sweeps: extremes, out-of-range codes and random sizes
        for (n = 0; n < 8; n++)
        begin
            case (n)
                0: begin write_canvas(REG_CANVAS_COLS, 13'd2);
                         write_canvas(REG_CANVAS_ROWS, 13'd4096); end
                1: begin write_canvas(REG_CANVAS_COLS, 13'd4096);
                         write_canvas(REG_CANVAS_ROWS, 13'd2); end
                2: begin write_canvas(REG_CANVAS_COLS, 13'd0);
                         write_canvas(REG_CANVAS_ROWS, 13'h1fff); end
                3: begin write_canvas(REG_CANVAS_COLS, 13'h1fff);
                         write_canvas(REG_CANVAS_ROWS, 13'd1); end
                default: begin
                    write_canvas(REG_CANVAS_COLS, CFG_W'($urandom));
                    write_canvas(REG_CANVAS_ROWS, CFG_W'($urandom_range(2, 4096)));
                end
            endcase
            repeat (150)
                send_temp(random_temp(), n % 3 != 0);
            start <= 1'b0;
            drain_results();
        end

        drain_results();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
